/* src/assert_macros.svh */
// Assertion macros used by the RTL of the disk clip block.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define DRC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define DRC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/drc_pkg.sv */
// Package for the disk clip block: fixed-point constants, seed table,
// stage-advance struct of the Newton step. No dependencies.
package drc_pkg;

	localparam int RadiusReset = 1024;
	localparam int FracBits    = 18;

	// Q2.30 constants of the inverse square root, plus the Q.18 one of the clip factor and the seed index offset and count
	localparam logic [63:0] RND29     = 64'd1 << 29;
	localparam logic [64:0] RND30     = 65'd1 << 30;
	localparam logic [35:0] THREE_Q30 = 36'd3 << 30;
	localparam logic [33:0] TWO_Q30   = 34'd2 << 30;
	localparam logic [18:0] F_ONE     = 19'd1 << FracBits;
	localparam logic [4:0]  SEED_OFS  = 5'd8;
	localparam logic [4:0]  SEED_CNT  = 5'd24;

	typedef struct packed {
		logic st1;
		logic st2;
		logic st3;
	} nstep_adv_t;

	// 1/sqrt(M) seeds, Q.16, midpoints of 1/8 steps over [1,4)
	function automatic logic [15:0] seed_lookup(input logic [4:0] idx);
		logic [15:0] v;
		case (idx)
			5'd0:  v = 16'd63579;
			5'd1:  v = 16'd60140;
			5'd2:  v = 16'd57204;
			5'd3:  v = 16'd54661;
			5'd4:  v = 16'd52429;
			5'd5:  v = 16'd50450;
			5'd6:  v = 16'd48679;
			5'd7:  v = 16'd47083;
			5'd8:  v = 16'd45633;
			5'd9:  v = 16'd44310;
			5'd10: v = 16'd43096;
			5'd11: v = 16'd41977;
			5'd12: v = 16'd40940;
			5'd13: v = 16'd39977;
			5'd14: v = 16'd39078;
			5'd15: v = 16'd38238;
			5'd16: v = 16'd37449;
			5'd17: v = 16'd36708;
			5'd18: v = 16'd36008;
			5'd19: v = 16'd35348;
			5'd20: v = 16'd34722;
			5'd21: v = 16'd34128;
			5'd22: v = 16'd33564;
			5'd23: v = 16'd33027;
			default: v = 16'd63579;
		endcase
		return v;
	endfunction

endpackage

/* src/drc_ifs.sv */
// Stream interfaces of the disk clip block: input vectors and projected results.
// No dependencies.
interface drc_vec_if #(parameter int W = 16) ();
	logic                valid;
	logic                ready;
	logic signed [W-1:0] vec_x;
	logic signed [W-1:0] vec_y;
	logic                frame_end;

	modport source (output valid, vec_x, vec_y, frame_end, input ready);
	modport sink   (input valid, vec_x, vec_y, frame_end, output ready);
endinterface

interface drc_proj_if #(parameter int W = 16) ();
	logic                valid;
	logic                ready;
	logic signed [W-1:0] proj_x;
	logic signed [W-1:0] proj_y;
	logic                clipped;
	logic                frame_end_out;

	modport source (output valid, proj_x, proj_y, clipped, frame_end_out, input ready);
	modport sink   (input valid, proj_x, proj_y, clipped, frame_end_out, output ready);
endinterface

/* src/drc_newton_step.sv */
// One Newton refinement of 1/sqrt(M) in three register stages.
// Depends on drc_pkg.
module drc_newton_step (
	input  logic              clk,
	input  drc_pkg::nstep_adv_t adv,
	input  logic [31:0]       mq_i,
	input  logic [31:0]       y_i,
	output logic [31:0]       mq_o,
	output logic [31:0]       y_o
);
	import drc_pkg::*;

	logic [32:0] t_s1;
	logic [31:0] mq_s1, y_s1;
	logic [31:0] h_s2, mq_s2, y_s2;
	logic [31:0] mq_s3, y_s3;

	logic [63:0] sq;
	logic [65:0] mt;
	logic [35:0] u;
	logic [64:0] yh;
	logic [33:0] yn;

	always_comb begin
		sq = 64'(y_i) * 64'(y_i) + RND29;
		mt = 66'(mq_s1) * 66'(t_s1) + 66'(RND29);
		u  = mt[65:30];
		yh = 65'(y_s2) * 65'(h_s2) + RND30;
		yn = yh[64:31];
	end

	always_ff @(posedge clk) begin
		if (adv.st1) begin
			t_s1  <= sq[62:30];
			mq_s1 <= mq_i;
			y_s1  <= y_i;
		end
		if (adv.st2) begin
			h_s2  <= (u >= THREE_Q30) ? 32'd0 : 32'(THREE_Q30 - u);
			mq_s2 <= mq_s1;
			y_s2  <= y_s1;
		end
		if (adv.st3) begin
			y_s3  <= (yn > TWO_Q30) ? 32'(TWO_Q30) : yn[31:0];
			mq_s3 <= mq_s2;
		end
	end

	assign mq_o = mq_s3;
	assign y_o  = y_s3;
endmodule

/* src/disk_radius_clip_2d.sv */
// Disk clip of 2-D vectors: one vector per cycle while the output is not stalled.
// Each stage holds its beat until the next stage frees, so a stall at the output
// backs up stage by stage; bubbles are squeezed out.
// Every stage is pipelined and advances on its own, so only a stall at the output limits the rate.
// Reset clears all stage valid bits and sets the radius to 1024 (masked to width).
module disk_radius_clip_2d #(
	parameter int DATA_WIDTH   = 16,
	parameter int NEWTON_STEPS = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [DATA_WIDTH-1:0] cfg_wdata,
	drc_vec_if.sink               vec,
	drc_proj_if.source            proj
);
	import drc_pkg::*;

	localparam int W   = DATA_WIDTH;
	localparam int BLW = $clog2(2 * W + 1);
	localparam int SHW = $clog2(W + 12);
	localparam int KF1 = 6 + 3 * NEWTON_STEPS;
	localparam int KF2 = KF1 + 1;
	localparam int KA1 = KF1 + 2;
	localparam int N   = KF1 + 3;

	typedef struct packed {
		logic signed [W-1:0] x;
		logic signed [W-1:0] y;
		logic                fe;
		logic                clip;
		logic [SHW-1:0]      sh;
	} ctx_t;

	logic [W-1:0] radius_q;
	logic [N:1]   v_q;
	logic [N+1:1] en;
	ctx_t         ctx_s [1:N];
	ctx_t         ctx_d [1:N];

	logic [2*W-1:0] ax2_s1, ay2_s1, rr_s1;
	logic [2*W-1:0] r2_s2, r2_s3;
	logic [BLW-1:0] ble_s3;
	logic [31:0]    mq_s4, mq_s5, y_s5;
	logic [W+31:0]  prod_f1;
	logic [18:0]    f_f2;
	logic [W+18:0]  mx_a1, my_a1;
	logic signed [W-1:0] px_a2, py_a2;

	logic [31:0] mq_n [0:NEWTON_STEPS];
	logic [31:0] y_n  [0:NEWTON_STEPS];

	logic [W-1:0]   ax_in, ay_in, ax_c, ay_c;
	logic [2*W-1:0] r2_d;
	logic [BLW-1:0] bl;
	logic [BLW-1:0] ble_d;
	logic [63:0]    r2w;
	logic [4:0]     sidx;
	logic [W+32:0]  fsum, fshift;
	logic [W+18:0]  mxr, myr;
	logic [W-1:0]   mx_m, my_m;
	logic           in_acc, out_acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= W'(RadiusReset);
		end else if (cfg_we) begin
			radius_q <= cfg_wdata;
		end
	end

	// stage k may load when empty or when its beat moves on
	always_comb begin
		en[N+1] = proj.ready;
		for (int k = N; k >= 1; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end

	assign vec.ready = en[1];
	assign in_acc    = vec.valid && vec.ready;
	assign out_acc   = proj.valid && proj.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[1]) v_q[1] <= vec.valid;
			for (int k = 2; k <= N; k++) begin
				if (en[k]) v_q[k] <= v_q[k-1];
			end
		end
	end

	always_comb begin
		ax_in = vec.vec_x[W-1] ? W'(-vec.vec_x) : W'(vec.vec_x);
		ay_in = vec.vec_y[W-1] ? W'(-vec.vec_y) : W'(vec.vec_y);
		r2_d  = ax2_s1 + ay2_s1;
		bl    = '0;
		for (int i = 0; i < 2 * W; i++) begin
			if (r2_s2[i]) bl = BLW'(i + 1);
		end
		// round bit length up to even so the exponent stays even
		ble_d = bl + BLW'(bl[0]);
		r2w   = 64'(r2_s3);
		sidx  = mq_s4[31:27] - SEED_OFS;
		if (sidx >= SEED_CNT) sidx = sidx - SEED_CNT;

		ctx_d[1].x    = vec.vec_x;
		ctx_d[1].y    = vec.vec_y;
		ctx_d[1].fe   = vec.frame_end;
		ctx_d[1].clip = 1'b0;
		ctx_d[1].sh   = '0;
		for (int k = 2; k <= N; k++) begin
			ctx_d[k] = ctx_s[k-1];
		end
		ctx_d[2].clip = r2_d > rr_s1;
		ctx_d[3].sh   = SHW'(11) + SHW'(ble_d >> 1);

		fsum   = (W+33)'(prod_f1) + ((W+33)'(1) << (ctx_s[KF1].sh - SHW'(1)));
		fshift = fsum >> ctx_s[KF1].sh;

		ax_c = ctx_s[KF2].x[W-1] ? W'(-ctx_s[KF2].x) : W'(ctx_s[KF2].x);
		ay_c = ctx_s[KF2].y[W-1] ? W'(-ctx_s[KF2].y) : W'(ctx_s[KF2].y);

		mxr  = mx_a1 + (W+19)'(F_ONE >> 1);
		myr  = my_a1 + (W+19)'(F_ONE >> 1);
		mx_m = mxr[W+17:18];
		my_m = myr[W+17:18];
	end

	always_ff @(posedge clk) begin
		for (int k = 1; k <= N; k++) begin
			if (en[k]) ctx_s[k] <= ctx_d[k];
		end
		if (en[1]) begin
			ax2_s1 <= (2*W)'(ax_in) * (2*W)'(ax_in);
			ay2_s1 <= (2*W)'(ay_in) * (2*W)'(ay_in);
			rr_s1  <= (2*W)'(radius_q) * (2*W)'(radius_q);
		end
		if (en[2]) r2_s2 <= r2_d;
		if (en[3]) begin
			r2_s3  <= r2_s2;
			ble_s3 <= ble_d;
		end
		// normalize to Q2.30 in [1,4)
		if (en[4]) begin
			if (7'(ble_s3) >= 7'd32)
				mq_s4 <= 32'(r2w >> (7'(ble_s3) - 7'd32));
			else
				mq_s4 <= 32'(r2w << (7'd32 - 7'(ble_s3)));
		end
		if (en[5]) begin
			mq_s5 <= mq_s4;
			y_s5  <= 32'(seed_lookup(sidx)) << 14;
		end
		if (en[KF1]) prod_f1 <= (W+32)'(radius_q) * (W+32)'(y_n[NEWTON_STEPS]);
		if (en[KF2]) f_f2 <= (fshift > (W+33)'(F_ONE)) ? F_ONE : fshift[18:0];
		if (en[KA1]) begin
			mx_a1 <= (W+19)'(ax_c) * (W+19)'(f_f2);
			my_a1 <= (W+19)'(ay_c) * (W+19)'(f_f2);
		end
		if (en[N]) begin
			if (ctx_s[KA1].clip) begin
				px_a2 <= ctx_s[KA1].x[W-1] ? -$signed(mx_m) : $signed(mx_m);
				py_a2 <= ctx_s[KA1].y[W-1] ? -$signed(my_m) : $signed(my_m);
			end else begin
				px_a2 <= ctx_s[KA1].x;
				py_a2 <= ctx_s[KA1].y;
			end
		end
	end

	assign mq_n[0] = mq_s5;
	assign y_n[0]  = y_s5;

	for (genvar i = 0; i < NEWTON_STEPS; i++) begin : g_newton
		nstep_adv_t adv;
		assign adv.st1 = en[6 + 3*i];
		assign adv.st2 = en[7 + 3*i];
		assign adv.st3 = en[8 + 3*i];
		drc_newton_step u_step (
			.clk  (clk),
			.adv  (adv),
			.mq_i (mq_n[i]),
			.y_i  (y_n[i]),
			.mq_o (mq_n[i+1]),
			.y_o  (y_n[i+1])
		);
	end

	assign proj.valid         = v_q[N];
	assign proj.proj_x        = px_a2;
	assign proj.proj_y        = py_a2;
	assign proj.clipped       = ctx_s[N].clip;
	assign proj.frame_end_out = ctx_s[N].fe;

`include "assert_macros.svh"

	// input only blocks when the whole pipe is full and the output is stalled
	`DRC_ASSERT(a_ready_full, !vec.ready |-> (&v_q) && !proj.ready, "input stalled with room")
	// beats in flight change only by accepted beats
	`DRC_ASSERT(a_occupancy, arst_n && $past(arst_n) |-> $countones(v_q) == $countones($past(v_q)) + int'($past(in_acc)) - int'($past(out_acc)), "beat lost or duplicated")
	// zero radius collapses every clipped vector to the origin
	`DRC_ASSERT_ALWAYS(a_zero_radius, proj.valid && proj.clipped && radius_q == '0 |-> proj.proj_x == '0 && proj.proj_y == '0, "nonzero output at zero radius")

endmodule
